FILE: hdl/fpc_pkg.sv
`default_nettype none

package fpc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;
  localparam int LEVEL_W     = SAMPLE_BITS + FRAC_BITS;

  localparam int ALPHA_W     = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(9830);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET  = SAMPLE_BITS'((2 ** SAMPLE_BITS - 1) / 2);
  localparam logic [SAMPLE_BITS-1:0] DEAD_RESET    = SAMPLE_BITS'(80);
  localparam logic [1:0]             RANGE_RESET   = 2'd1;

  localparam int POS_W       = 16;
  localparam int POS_FRAC    = 14;
  localparam int MAG_W       = POS_FRAC + 1;
  localparam int PITCH_W     = 15;
  localparam int RANGE_W     = 13;
  localparam int PITCH_MAG_W = 29;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = ALPHA_W;

  localparam logic [CFG_INDEX_W-1:0] REG_EMA_WEIGHT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_MIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_MAX      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_CAL   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERTED     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_SELECT = 3'd6;

  localparam logic [1:0] RANGE_4PCT  = 2'd0;
  localparam logic [1:0] RANGE_8PCT  = 2'd1;
  localparam logic [1:0] RANGE_16PCT = 2'd2;
  localparam logic [1:0] RANGE_50PCT = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   bend_enable;
  } in_word_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_offset;
    logic signed [POS_W-1:0]   slider_position;
    logic                      at_center;
  } out_word_t;

  // Full-scale pitch in hundredths of a percent for each range code.
  function automatic logic [RANGE_W-1:0] range_hundredths(input logic [1:0] sel);
    logic [RANGE_W-1:0] r;
    case (sel)
      RANGE_4PCT:  r = RANGE_W'(400);
      RANGE_8PCT:  r = RANGE_W'(800);
      RANGE_16PCT: r = RANGE_W'(1600);
      RANGE_50PCT: r = RANGE_W'(5000);
      default:     r = RANGE_W'(800);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fader_position_conditioner_unit.sv
// Channel  Signals                         Direction  Payload
// input    in_valid / in_ready / in_data    in         fpc_pkg::in_word_t
// output   out_valid / out_ready / out_data out        fpc_pkg::out_word_t
// config   cfg_write / cfg_index / cfg_data in         register write, no read-back
//
// A word passes from acceptance through the filter multiply and accumulate, the
// dead-zone test, a 15-step restoring divider for the position, then the pitch multiply.
// The next word is taken in the cycle after the result loads.
// A word in the dead zone skips the divider setup and the divider; a saturated one skips the divider.
// Synchronous reset restores registers and the filter level to the center value.
// A finished word waits in the output register; a stalled output holds the last
// step until the register frees, and in_ready stays low while a word is in work.
`default_nettype none

module fader_position_conditioner_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire fpc_pkg::in_word_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output fpc_pkg::out_word_t                       out_data,
  input  wire logic                                cfg_write,
  input  wire logic [fpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [fpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SB      = fpc_pkg::SAMPLE_BITS;
  localparam int FB      = fpc_pkg::FRAC_BITS;
  localparam int LW      = fpc_pkg::LEVEL_W;
  localparam int AW      = fpc_pkg::ALPHA_W;
  localparam int MB_W    = LW + 1;
  localparam int PROD_W  = AW + 1 + MB_W;
  localparam int DW      = LW + 3;
  localparam int X_W     = LW + 1;
  localparam int MAG_W   = fpc_pkg::MAG_W;
  localparam int POS_W   = fpc_pkg::POS_W;
  localparam int PW      = fpc_pkg::PITCH_W;
  localparam int PM_W    = fpc_pkg::PITCH_MAG_W;
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int SPAN_W  = SB + 3;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);
  localparam logic [MAG_W-1:0] MAG_ONE   = MAG_W'(2 ** fpc_pkg::POS_FRAC);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILT  = 4'd1;
  localparam logic [3:0] S_LEVEL = 4'd2;
  localparam logic [3:0] S_POS   = 4'd3;
  localparam logic [3:0] S_SETUP = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MAG   = 4'd6;
  localparam logic [3:0] S_PMUL  = 4'd7;
  localparam logic [3:0] S_PITCH = 4'd8;

  // Configuration registers.
  logic [AW-1:0] ema_weight;
  logic [SB-1:0] raw_min;
  logic [SB-1:0] raw_max;
  logic [SB-1:0] center_cal;
  logic [SB-1:0] deadband;
  logic          inverted;
  logic [1:0]    range_select;

  // State carried between words.
  logic [LW-1:0]           level;
  logic signed [POS_W-1:0] last_position;
  logic                    bend_active;
  logic signed [POS_W-1:0] bend_base;

  // Per-word working registers.
  logic [3:0]               state;
  logic [SB-1:0]            smp;
  logic signed [PROD_W-1:0] prod;
  logic                     centered;
  logic                     below;
  logic [LW-1:0]            num;
  logic [SB-1:0]            span;
  logic [X_W-1:0]           rem;
  logic [X_W-1:0]           dv;
  logic [MAG_W-1:0]         quot;
  logic                     sat;
  logic [CNT_W-1:0]         step;

  // Shared multiplier.
  logic [AW-1:0]            alpha_eff;
  logic signed [MB_W-1:0]   filt_diff;
  logic signed [POS_W:0]    pitch_diff;
  logic [AW-1:0]            mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    alpha_eff  = (ema_weight > fpc_pkg::ALPHA_ONE) ? fpc_pkg::ALPHA_ONE : ema_weight;
    filt_diff  = $signed({1'b0, smp, {FB{1'b0}}}) - $signed({1'b0, level});
    pitch_diff = $signed({last_position[POS_W-1], last_position})
               - (bend_active ? $signed({bend_base[POS_W-1], bend_base})
                              : $signed({(POS_W+1){1'b0}}));
    if (state == S_FILT) begin
      mul_a = alpha_eff;
      mul_b = filt_diff;
    end else begin
      mul_a = AW'(fpc_pkg::range_hundredths(range_select));
      mul_b = MB_W'(pitch_diff);
    end
    mul_p = $signed({1'b0, mul_a}) * mul_b;
  end

  // Filter update: level + round(alpha * (sample - level)).
  logic signed [PROD_W-1:0] prod_rnd;
  logic [LW-1:0]            level_next;
  always_comb begin
    prod_rnd   = (prod + $signed(PROD_W'(2 ** (FB - 1)))) >>> FB;
    level_next = level + prod_rnd[LW-1:0];
  end

  // Dead-zone edges and spans.
  logic signed [DW-1:0]     lvl_s;
  logic signed [DW-1:0]     lo_edge;
  logic signed [DW-1:0]     hi_edge;
  logic signed [DW-1:0]     dist_lo;
  logic signed [DW-1:0]     dist_hi;
  logic signed [SPAN_W-1:0] span_lo;
  logic signed [SPAN_W-1:0] span_hi;
  logic signed [SPAN_W-1:0] span_sel;
  always_comb begin
    lvl_s    = $signed(DW'(level));
    lo_edge  = ($signed(DW'(center_cal)) - $signed(DW'(deadband))) <<< FB;
    hi_edge  = ($signed(DW'(center_cal)) + $signed(DW'(deadband))) <<< FB;
    dist_lo  = lo_edge - lvl_s;
    dist_hi  = lvl_s - hi_edge;
    span_lo  = $signed(SPAN_W'(center_cal)) - $signed(SPAN_W'(deadband))
             - $signed(SPAN_W'(raw_min));
    span_hi  = $signed(SPAN_W'(raw_max)) - $signed(SPAN_W'(center_cal))
             - $signed(SPAN_W'(deadband));
    span_sel = (dist_lo > 0) ? span_lo : span_hi;
  end

  // Divider setup: magnitude = floor((num + 2*span) / (4*span)).
  logic [X_W-1:0] div_x;
  logic [X_W-1:0] div_d;
  always_comb begin
    div_x = X_W'(num) + X_W'({span, 1'b0});
    div_d = X_W'({span, 2'b00});
  end

  logic [MAG_W-1:0]        mag;
  logic signed [POS_W-1:0] pos_calc;
  always_comb begin
    if (sat || quot > MAG_ONE) begin
      mag = MAG_ONE;
    end else if (quot == '0) begin
      mag = MAG_W'(1);
    end else begin
      mag = quot;
    end
    if (centered) begin
      pos_calc = '0;
    end else if (below ^ inverted) begin
      pos_calc = -$signed(POS_W'(mag));
    end else begin
      pos_calc = $signed(POS_W'(mag));
    end
  end

  // Pitch rounding, ties away from zero.
  logic [PM_W-1:0] pm_abs;
  logic [PM_W-1:0] pm_rnd;
  logic [PW-1:0]   pitch_mag;
  logic [PW-1:0]   pitch_val;
  always_comb begin
    pm_abs    = prod[PROD_W-1] ? PM_W'(-prod) : PM_W'(prod);
    pm_rnd    = pm_abs + PM_W'(2 ** (fpc_pkg::POS_FRAC - 1));
    pitch_mag = PW'(pm_rnd >> fpc_pkg::POS_FRAC);
    pitch_val = prod[PROD_W-1] ? -pitch_mag : pitch_mag;
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_weight   <= fpc_pkg::ALPHA_RESET;
      raw_min      <= '0;
      raw_max      <= fpc_pkg::SAMPLE_MAX;
      center_cal   <= fpc_pkg::CENTER_RESET;
      deadband     <= fpc_pkg::DEAD_RESET;
      inverted     <= 1'b0;
      range_select <= fpc_pkg::RANGE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fpc_pkg::REG_EMA_WEIGHT:   ema_weight   <= cfg_data;
        fpc_pkg::REG_RAW_MIN:      raw_min      <= cfg_data[SB-1:0];
        fpc_pkg::REG_RAW_MAX:      raw_max      <= cfg_data[SB-1:0];
        fpc_pkg::REG_CENTER_CAL:   center_cal   <= cfg_data[SB-1:0];
        fpc_pkg::REG_DEADBAND:     deadband     <= cfg_data[SB-1:0];
        fpc_pkg::REG_INVERTED:     inverted     <= cfg_data[0];
        fpc_pkg::REG_RANGE_SELECT: range_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      level         <= {fpc_pkg::CENTER_RESET, {FB{1'b0}}};
      last_position <= '0;
      bend_active   <= 1'b0;
      bend_base     <= '0;
      out_valid     <= 1'b0;
    end else begin
      // In the final step the output register is reloaded instead.
      if (out_valid && out_ready && state != S_PITCH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp <= in_data.sample;
            // The bend reference is the position of the previous word.
            if (in_data.bend_enable && !bend_active) begin
              bend_base <= last_position;
            end
            bend_active <= in_data.bend_enable;
            state       <= S_FILT;
          end
        end
        S_FILT: begin
          prod  <= mul_p;
          state <= S_LEVEL;
        end
        S_LEVEL: begin
          level <= level_next;
          state <= S_POS;
        end
        S_POS: begin
          below    <= dist_lo > 0;
          centered <= !(dist_lo > 0) && !(dist_hi > 0);
          num      <= (dist_lo > 0) ? LW'(dist_lo) : LW'(dist_hi);
          span     <= (span_sel > 0) ? SB'(span_sel) : SB'(1);
          if (!(dist_lo > 0) && !(dist_hi > 0)) begin
            state <= S_MAG;
          end else begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          rem   <= div_x;
          dv    <= div_d << (MAG_W - 1);
          quot  <= '0;
          step  <= '0;
          // Quotient too wide for the divider saturates to full scale.
          sat   <= (div_x >= (div_d << MAG_W));
          state <= (div_x >= (div_d << MAG_W)) ? S_MAG : S_DIV;
        end
        S_DIV: begin
          if (rem >= dv) begin
            rem  <= rem - dv;
            quot <= {quot[MAG_W-2:0], 1'b1};
          end else begin
            quot <= {quot[MAG_W-2:0], 1'b0};
          end
          dv   <= dv >> 1;
          step <= step + CNT_W'(1);
          if (step == LAST_STEP) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          last_position <= pos_calc;
          state         <= S_PMUL;
        end
        S_PMUL: begin
          prod  <= mul_p;
          state <= S_PITCH;
        end
        S_PITCH: begin
          if (out_free) begin
            out_data.pitch_offset    <= $signed(pitch_val);
            out_data.slider_position <= last_position;
            out_data.at_center       <= centered;
            out_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_POS) begin
        sat <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
